/* hw/rtl/cwf_pkg.sv */
// Shared types and constants for the causal 3x3-style window filter.
// Used by the channel interfaces, the register block, the MAC pipeline
// and the top level. No dependencies.
package cwf_pkg;

  // Field widths fixed by the channel and register definitions
  localparam int PIX_W     = 16;
  localparam int WIDX_W    = 4;
  localparam int ACC_W     = 40;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int NEAR_W    = 3;
  localparam int NEAR_MAX  = 7;
  localparam int BIAS_SHL  = 14;

  // APB register map
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;
  localparam logic [1:0] REG_BIAS   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd1024;

  // Input item kinds
  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  typedef struct packed {
    logic signed [PIX_W-1:0] bias;
    logic [SIZE_W-1:0]       width;
    logic [SIZE_W-1:0]       height;
  } cfg_t;

  // Per-item tag that travels with the data down the pipeline
  typedef struct packed {
    logic                    is_weight;
    logic [WIDX_W-1:0]       widx;
    logic signed [PIX_W-1:0] wval;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic [NEAR_W-1:0]       col_near;
    logic                    last;
  } meta_t;

endpackage

/* hw/rtl/cwf_in_if.sv */
// Input channel: pixel or weight-write items with valid/ready.
// Depends on cwf_pkg for field widths.
interface cwf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [cwf_pkg::PIX_W-1:0] pixel;
  logic [cwf_pkg::WIDX_W-1:0]       weight_index;
  logic signed [cwf_pkg::PIX_W-1:0] weight_value;

  modport source (output valid, mode, pixel, weight_index, weight_value, input ready);
  modport sink   (input valid, mode, pixel, weight_index, weight_value, output ready);
endinterface

/* hw/rtl/cwf_out_if.sv */
// Result channel: filtered pixel with position and frame marker.
// Depends on cwf_pkg for field widths.
interface cwf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cwf_pkg::ACC_W-1:0] result;
  logic [cwf_pkg::POS_W-1:0]        out_row;
  logic [cwf_pkg::POS_W-1:0]        out_col;
  logic                             last_of_frame;

  modport source (output valid, result, out_row, out_col, last_of_frame, input ready);
  modport sink   (input valid, result, out_row, out_col, last_of_frame, output ready);
endinterface

/* hw/rtl/cwf_cfg_regs.sv */
// APB register block: bias, frame width and frame height.
// Depends on cwf_pkg for the register map and cfg_t.
module cwf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cwf_pkg::APB_AW-1:0]  paddr,
  input  logic [cwf_pkg::APB_DW-1:0]  pwdata,
  output logic [cwf_pkg::APB_DW-1:0]  prdata,
  output cwf_pkg::cfg_t               cfg
);

  logic [1:0]    reg_idx;
  logic          wr_en;
  cwf_pkg::cfg_t cfg_r;

  assign reg_idx = paddr[cwf_pkg::APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Write on the access phase of an APB transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias   <= '0;
      cfg_r.width  <= cwf_pkg::RST_WIDTH;
      cfg_r.height <= cwf_pkg::RST_HEIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        cwf_pkg::REG_BIAS:   cfg_r.bias   <= pwdata[cwf_pkg::PIX_W-1:0];
        cwf_pkg::REG_WIDTH:  cfg_r.width  <= pwdata[cwf_pkg::SIZE_W-1:0];
        cwf_pkg::REG_HEIGHT: cfg_r.height <= pwdata[cwf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the stored values
  always_comb begin
    case (reg_idx)
      cwf_pkg::REG_BIAS:   prdata = cwf_pkg::APB_DW'(unsigned'(cfg_r.bias));
      cwf_pkg::REG_WIDTH:  prdata = cwf_pkg::APB_DW'(cfg_r.width);
      cwf_pkg::REG_HEIGHT: prdata = cwf_pkg::APB_DW'(cfg_r.height);
      default:             prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/cwf_line_mem.sv */
// Line memory: one entry per column holding that column's recent rows.
// Registered (synchronous) read, with a write-first bypass on a
// same-address read and write. No dependencies.
module cwf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward the write data when the read hits the entry written this cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule

/* hw/rtl/cwf_mac.sv */
// Window, weight store and multiply-accumulate pipeline with the output
// register. Depends on cwf_pkg and cwf_out_if.
module cwf_mac #(
  parameter int WIN_SIZE = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cwf_pkg::meta_t                   in_meta,
  input  logic signed [cwf_pkg::PIX_W-1:0] col_i [WIN_SIZE],
  input  logic signed [cwf_pkg::PIX_W-1:0] bias,
  cwf_out_if.source                        out_ch
);

  localparam int K     = WIN_SIZE;
  localparam int TAPS  = K * K;
  localparam int PIX_W = cwf_pkg::PIX_W;
  localparam int PRD_W = 2 * PIX_W;
  localparam int ACC_W = cwf_pkg::ACC_W;

  // Stage M0: window and tag
  logic                    m0_v_r, m0_v_nxt;
  cwf_pkg::meta_t          m0_meta_r;
  logic signed [PIX_W-1:0] win_r [K][K];
  logic signed [PIX_W-1:0] wstore_r [TAPS];
  // Stage M1: products
  logic                    m1_v_r, m1_v_nxt;
  cwf_pkg::meta_t          m1_meta_r;
  logic signed [PRD_W-1:0] prod_r [K][K];
  // Stage M2: row sums
  logic                    m2_v_r, m2_v_nxt;
  cwf_pkg::meta_t          m2_meta_r;
  logic signed [ACC_W-1:0] rsum_r [K];
  logic signed [ACC_W-1:0] rsum_c [K];
  // Output register
  logic                    out_v_r, out_v_nxt;
  logic signed [ACC_W-1:0] result_r;
  logic signed [ACC_W-1:0] total_c;
  cwf_pkg::meta_t          out_meta_r;

  logic in_fire, m0_fire, m1_fire, m2_fire, out_fire;
  logic m1_rdy, m2_rdy, o_rdy;

  // Handshake chain: a stage takes a new item when empty or draining
  assign o_rdy    = !out_v_r || out_ch.ready;
  assign m2_rdy   = !m2_v_r || o_rdy;
  assign m1_rdy   = !m1_v_r || m2_rdy;
  assign in_ready = !m0_v_r || m1_rdy;
  assign in_fire  = in_valid && in_ready;
  assign m0_fire  = m0_v_r && m1_rdy;
  assign m1_fire  = m1_v_r && m2_rdy;
  assign m2_fire  = m2_v_r && o_rdy;
  assign out_fire = out_v_r && out_ch.ready;

  always_comb begin
    m0_v_nxt  = in_fire ? 1'b1 : (m0_fire ? 1'b0 : m0_v_r);
    m1_v_nxt  = (m0_fire && !m0_meta_r.is_weight) ? 1'b1 : (m1_fire ? 1'b0 : m1_v_r);
    m2_v_nxt  = m1_fire ? 1'b1 : (m2_fire ? 1'b0 : m2_v_r);
    out_v_nxt = m2_fire ? 1'b1 : (out_fire ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_v_r  <= 1'b0;
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      m0_v_r  <= m0_v_nxt;
      m1_v_r  <= m1_v_nxt;
      m2_v_r  <= m2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Advance the window by one column for each pixel transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m0_meta_r <= in_meta;
      if (!in_meta.is_weight) begin
        for (int a = 0; a < K; a++) begin
          win_r[a][0] <= col_i[a];
          for (int b = 1; b < K; b++) begin
            win_r[a][b] <= win_r[a][b-1];
          end
        end
      end
    end
  end

  // Load weights in stream order, behind any pixel already past M0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TAPS; t++) begin
        wstore_r[t] <= '0;
      end
    end else if (m0_fire && m0_meta_r.is_weight) begin
      for (int t = 0; t < TAPS; t++) begin
        if (int'(m0_meta_r.widx) == t) begin
          wstore_r[t] <= m0_meta_r.wval;
        end
      end
    end
  end

  // Multiply; columns left of the frame drop out
  always_ff @(posedge clk) begin
    if (m0_fire && !m0_meta_r.is_weight) begin
      m1_meta_r <= m0_meta_r;
      for (int a = 0; a < K; a++) begin
        for (int b = 0; b < K; b++) begin
          if (int'(m0_meta_r.col_near) < b) begin
            prod_r[a][b] <= '0;
          end else begin
            prod_r[a][b] <= win_r[a][b] * wstore_r[(K-1-a)*K + (K-1-b)];
          end
        end
      end
    end
  end

  // Sum each window row
  always_comb begin
    for (int a = 0; a < K; a++) begin
      rsum_c[a] = '0;
      for (int b = 0; b < K; b++) begin
        rsum_c[a] = rsum_c[a] + ACC_W'(prod_r[a][b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m1_fire) begin
      m2_meta_r <= m1_meta_r;
      for (int a = 0; a < K; a++) begin
        rsum_r[a] <= rsum_c[a];
      end
    end
  end

  // Add row sums and the aligned bias
  always_comb begin
    total_c = ACC_W'(bias) <<< cwf_pkg::BIAS_SHL;
    for (int a = 0; a < K; a++) begin
      total_c = total_c + rsum_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (m2_fire) begin
      result_r   <= total_c;
      out_meta_r <= m2_meta_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.result        = result_r;
  assign out_ch.out_row       = out_meta_r.row;
  assign out_ch.out_col       = out_meta_r.col;
  assign out_ch.last_of_frame = out_meta_r.last;

  a_weight_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (m0_fire && m0_meta_r.is_weight && !m1_v_r) |=> !m1_v_r)
    else $error("weight item produced a product stage entry");

  a_sum_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    m2_fire |=> out_v_r)
    else $error("row sums left M2 without landing in the output register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(result_r)))
    else $error("result changed while the output was stalled");

endmodule

/* hw/rtl/conv2d_causal_window_filter_unit.sv */
// Top level of the causal window filter: position counters, line memory
// read-modify-write and hand-off to the MAC pipeline.
// Depends on cwf_pkg, cwf_in_if, cwf_out_if, cwf_cfg_regs, cwf_line_mem, cwf_mac.
//
//   port group  | dir | handshake              | carries
//   in_ch       | in  | valid/ready            | mode, pixel, weight_index, weight_value
//   out_ch      | out | valid/ready            | result, out_row, out_col, last_of_frame
//   APB (p*)    | in  | psel/penable, pready=1 | bias, image_width, image_height
//
// One item per clock sustained while out_ch is not stalled; a result passes through
// S1, M0, M1, M2 and the output register after its pixel transfer. The line memory
// is read once per pixel and written back as the pixel leaves S1; a same-column
// read in the write-back cycle takes the bypassed write data.
// Reset is synchronous, active low; no clearing pass, line memory starts unknown.
// A stalled output fills the pipeline stages before in_ch.ready drops.
module conv2d_causal_window_filter_unit #(
  parameter int WIN_SIZE   = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cwf_in_if.sink                     in_ch,
  cwf_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cwf_pkg::APB_AW-1:0] paddr,
  input  logic [cwf_pkg::APB_DW-1:0] pwdata,
  output logic [cwf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int K      = WIN_SIZE;
  localparam int PIX_W  = cwf_pkg::PIX_W;
  localparam int NEAR_W = cwf_pkg::NEAR_W;
  localparam int LR     = (K > 1) ? K - 1 : 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WSZ_W  = CW + 1;
  localparam int HSZ_W  = RW + 1;

  cwf_pkg::cfg_t cfg;

  logic [CW-1:0]    col_count_r, col_count_nxt;
  logic [RW-1:0]    row_count_r, row_count_nxt;
  logic [WSZ_W-1:0] eff_w;
  logic [HSZ_W-1:0] eff_h;
  logic             last_col, last_row;
  logic             in_fire, acc_pix;

  // Stage S1: item waiting on line memory data
  logic                    s1_v_r, s1_v_nxt;
  cwf_pkg::meta_t          s1_meta_r;
  logic signed [PIX_W-1:0] s1_pixel_r;
  logic [CW-1:0]           s1_addr_r;
  logic [NEAR_W-1:0]       s1_row_near_r;

  logic                        mac_in_rdy;
  cwf_pkg::meta_t              meta_c;
  logic signed [PIX_W-1:0]     col_c [K];
  logic [LR-1:0][PIX_W-1:0]    mem_rd_data;
  logic [LR-1:0][PIX_W-1:0]    mem_wr_data;
  logic                        mem_rd_en, mem_wr_en;

  assign pready = 1'b1;

  cwf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Clamp frame size to the supported range
  always_comb begin
    if (cfg.width == '0) begin
      eff_w = WSZ_W'(1);
    end else if (int'(cfg.width) > MAX_WIDTH) begin
      eff_w = WSZ_W'(MAX_WIDTH);
    end else begin
      eff_w = WSZ_W'(cfg.width);
    end
    if (cfg.height == '0) begin
      eff_h = HSZ_W'(1);
    end else if (int'(cfg.height) > MAX_HEIGHT) begin
      eff_h = HSZ_W'(MAX_HEIGHT);
    end else begin
      eff_h = HSZ_W'(cfg.height);
    end
  end

  assign in_ch.ready = !s1_v_r || mac_in_rdy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign acc_pix     = in_fire && (in_ch.mode == cwf_pkg::MODE_PIXEL);
  assign last_col    = ({1'b0, col_count_r} + WSZ_W'(1)) >= eff_w;
  assign last_row    = ({1'b0, row_count_r} + HSZ_W'(1)) >= eff_h;

  // Advance raster position per pixel transfer, wrap at row and frame end
  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (acc_pix) begin
      if (last_col) begin
        col_count_nxt = '0;
        row_count_nxt = last_row ? '0 : row_count_r + RW'(1);
      end else begin
        col_count_nxt = col_count_r + CW'(1);
      end
    end
  end

  // Tag for the transfer
  always_comb begin
    meta_c.is_weight = (in_ch.mode == cwf_pkg::MODE_WEIGHT);
    meta_c.widx      = in_ch.weight_index;
    meta_c.wval      = in_ch.weight_value;
    meta_c.row       = cwf_pkg::POS_W'(row_count_r);
    meta_c.col       = cwf_pkg::POS_W'(col_count_r);
    meta_c.col_near  = (int'(col_count_r) > cwf_pkg::NEAR_MAX) ?
                       NEAR_W'(cwf_pkg::NEAR_MAX) : NEAR_W'(col_count_r);
    meta_c.last      = last_col && last_row;
  end

  assign s1_v_nxt = in_fire ? 1'b1 : ((s1_v_r && mac_in_rdy) ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      s1_v_r      <= 1'b0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      s1_v_r      <= s1_v_nxt;
    end
  end

  // Hold the item while the line memory read completes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meta_r     <= meta_c;
      s1_pixel_r    <= in_ch.pixel;
      s1_addr_r     <= col_count_r;
      s1_row_near_r <= (int'(row_count_r) > cwf_pkg::NEAR_MAX) ?
                       NEAR_W'(cwf_pkg::NEAR_MAX) : NEAR_W'(row_count_r);
    end
  end

  // Column history: newest row first, oldest drops off on write-back
  assign mem_rd_en = acc_pix;
  assign mem_wr_en = s1_v_r && !s1_meta_r.is_weight && mac_in_rdy;

  always_comb begin
    mem_wr_data[0] = s1_pixel_r;
    for (int k = 1; k < LR; k++) begin
      mem_wr_data[k] = mem_rd_data[k-1];
    end
  end

  cwf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (LR * PIX_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (col_count_r),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // Window column for this pixel; rows above the frame read as zero
  always_comb begin
    col_c[0] = s1_pixel_r;
    for (int a = 1; a < K; a++) begin
      if (int'(s1_row_near_r) < a) begin
        col_c[a] = '0;
      end else begin
        col_c[a] = mem_rd_data[a-1];
      end
    end
  end

  cwf_mac #(
    .WIN_SIZE (K)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_v_r),
    .in_ready (mac_in_rdy),
    .in_meta  (s1_meta_r),
    .col_i    (col_c),
    .bias     (cfg.bias),
    .out_ch   (out_ch)
  );

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_pix && last_col) |=> (col_count_r == '0))
    else $error("column counter did not wrap after the last column");

  a_mem_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en && (col_count_r == s1_addr_r)) |=>
    (mem_rd_data == $past(mem_wr_data)))
    else $error("same-column read missed the write-back data");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !mac_in_rdy) |=> (s1_v_r && $stable(s1_addr_r)))
    else $error("S1 item lost while the MAC pipeline stalled");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for conv2d_causal_window_filter_unit: directed and random
// pixel/weight traffic, an in-bench causal 3x3 filter predictor, in-order checks.
// Depends on cwf_pkg, cwf_in_if, cwf_out_if and the filter RTL.
module tb;

  localparam int K            = 3;
  localparam int TAPS         = K * K;
  localparam int LINE_MAX     = 1024;
  localparam int ROWS_MAX     = 1024;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_CAP    = 100;
  localparam int PIX_W        = cwf_pkg::PIX_W;
  localparam int WIDX_W       = cwf_pkg::WIDX_W;
  localparam int ACC_W        = cwf_pkg::ACC_W;
  localparam int POS_W        = cwf_pkg::POS_W;
  localparam int SIZE_W       = cwf_pkg::SIZE_W;
  localparam int APB_AW       = cwf_pkg::APB_AW;
  localparam int APB_DW       = cwf_pkg::APB_DW;
  localparam int BIAS_SHL     = cwf_pkg::BIAS_SHL;

  typedef struct {
    logic                    mode;
    logic signed [PIX_W-1:0] pixel;
    logic [WIDX_W-1:0]       widx;
    logic signed [PIX_W-1:0] wval;
  } filt_item_t;

  typedef struct {
    logic signed [ACC_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } filt_px_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cwf_in_if  in_bus();
  cwf_out_if out_bus();

  conv2d_causal_window_filter_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and expectation stores
  filt_item_t pending_items[$];
  filt_px_t   expected_px[$];
  filt_item_t on_bus;
  filt_px_t   want;
  int         err_cnt;
  int         send_idle_pct;
  int         recv_stall_pct;

  // Filter state mirror
  logic signed [PIX_W-1:0] line_px [K][LINE_MAX];
  logic signed [PIX_W-1:0] kernel [TAPS];
  logic signed [PIX_W-1:0] bias_q;
  int                      frame_w;
  int                      frame_h;
  int                      row_pos;
  int                      col_pos;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Advance the filter mirror by one accepted transfer
  function automatic void apply_item(filt_item_t it);
    longint   acc;
    int       r;
    int       c;
    int       a;
    int       b;
    logic     last_c;
    logic     last_r;
    filt_px_t px;
    if (it.mode == cwf_pkg::MODE_WEIGHT) begin
      // drop writes past the last tap
      if (it.widx < TAPS) kernel[it.widx] = it.wval;
      return;
    end
    r = row_pos;
    c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
    line_px[r % K][c] = it.pixel;
    acc = longint'(bias_q) * (longint'(1) << BIAS_SHL);
    for (a = 0; a < K; a++) begin
      for (b = 0; b < K; b++) begin
        // taps above or left of the frame read as zero
        if (a <= r && b <= c)
          acc += longint'(line_px[(r - a) % K][c - b]) *
                 longint'(kernel[(K - 1 - a) * K + (K - 1 - b)]);
      end
    end
    last_c   = (c + 1 >= frame_w);
    last_r   = (r + 1 >= frame_h);
    px.value = acc[ACC_W-1:0];
    px.row   = r[POS_W-1:0];
    px.col   = c[POS_W-1:0];
    px.last  = last_c && last_r;
    expected_px.push_back(px);
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report(string msg);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [PIX_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic push_pixel(logic [PIX_W-1:0] v);
    filt_item_t it;
    it.mode  = cwf_pkg::MODE_PIXEL;
    it.pixel = v;
    it.widx  = WIDX_W'($urandom);
    it.wval  = PIX_W'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_weight(logic [WIDX_W-1:0] idx, logic [PIX_W-1:0] v);
    filt_item_t it;
    it.mode  = cwf_pkg::MODE_WEIGHT;
    it.pixel = PIX_W'($urandom);
    it.widx  = idx;
    it.wval  = v;
    pending_items.push_back(it);
  endtask

  // Input driver: hold the item until its transfer, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) apply_item(on_bus);
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          in_bus.mode         <= on_bus.mode;
          in_bus.pixel        <= on_bus.pixel;
          in_bus.weight_index <= on_bus.widx;
          in_bus.weight_value <= on_bus.wval;
          in_bus.valid        <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_px.size() == 0) begin
          report($sformatf("unexpected result %0d at (%0d,%0d)",
                           out_bus.result, out_bus.out_row, out_bus.out_col));
        end else begin
          want = expected_px.pop_front();
          if (out_bus.result !== want.value)
            report($sformatf("result %0d, want %0d at (%0d,%0d)",
                             out_bus.result, want.value, want.row, want.col));
          if (out_bus.out_row !== want.row)
            report($sformatf("out_row %0d, want %0d", out_bus.out_row, want.row));
          if (out_bus.out_col !== want.col)
            report($sformatf("out_col %0d, want %0d", out_bus.out_col, want.col));
          if (out_bus.last_of_frame !== want.last)
            report($sformatf("last_of_frame %b, want %b at (%0d,%0d)",
                             out_bus.last_of_frame, want.last, want.row, want.col));
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // APB write: setup then access; mirror the register once it lands
  task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cwf_pkg::REG_BIAS:   bias_q  = val[PIX_W-1:0];
      cwf_pkg::REG_WIDTH:  frame_w = clamp_size(val[SIZE_W-1:0], LINE_MAX);
      cwf_pkg::REG_HEIGHT: frame_h = clamp_size(val[SIZE_W-1:0], ROWS_MAX);
      default: ;
    endcase
  endtask

  // Wait until every item is sent and every result checked, then let the pipe empty
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_bus.valid || expected_px.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Finish the current frame so a wider line never reads unwritten columns
  task automatic pad_frame();
    int r;
    int c;
    r = row_pos;
    c = col_pos;
    do begin
      push_pixel(rand_sample());
      if (c + 1 >= frame_w) begin
        c = 0;
        r = (r + 1 >= frame_h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end while (r != 0 || c != 0);
    wait_idle();
  endtask

  task automatic run_phase(int w, int h, logic [PIX_W-1:0] b, int n,
                           int s_idle, int r_stall);
    int k;
    if (clamp_size(SIZE_W'(w), LINE_MAX) > frame_w && (row_pos != 0 || col_pos != 0))
      pad_frame();
    write_reg(cwf_pkg::REG_BIAS, {{(APB_DW-PIX_W){b[PIX_W-1]}}, b});
    write_reg(cwf_pkg::REG_WIDTH, APB_DW'(w));
    write_reg(cwf_pkg::REG_HEIGHT, APB_DW'(h));
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 3) == 0)
          push_weight(WIDX_W'($urandom_range(TAPS, 15)), rand_sample());
        else
          push_weight(WIDX_W'($urandom_range(0, TAPS - 1)), rand_sample());
      end else begin
        push_pixel(rand_sample());
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.mode          = cwf_pkg::MODE_PIXEL;
    in_bus.pixel         = '0;
    in_bus.weight_index  = '0;
    in_bus.weight_value  = '0;
    out_bus.ready        = 1'b0;
    err_cnt              = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    bias_q               = '0;
    frame_w              = int'(cwf_pkg::RST_WIDTH);
    frame_h              = int'(cwf_pkg::RST_HEIGHT);
    row_pos              = 0;
    col_pos              = 0;
    for (int t = 0; t < TAPS; t++) kernel[t] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme taps, dropped tap writes, one 4x3 frame of extreme pixels
    write_reg(cwf_pkg::REG_BIAS, 32'd32767);
    write_reg(cwf_pkg::REG_WIDTH, 32'd4);
    write_reg(cwf_pkg::REG_HEIGHT, 32'd3);
    push_weight(4'd0, 16'h8000);
    push_weight(4'd1, 16'h7fff);
    push_weight(4'd2, 16'h4000);
    push_weight(4'd3, 16'hc000);
    push_weight(4'd4, 16'h7fff);
    push_weight(4'd5, 16'h8000);
    push_weight(4'd6, 16'h0001);
    push_weight(4'd7, 16'hffff);
    push_weight(4'd8, 16'h7fff);
    push_weight(4'd9, 16'h7fff);
    push_weight(4'd15, 16'h8000);
    push_pixel(16'h8000);
    push_pixel(16'h7fff);
    push_pixel(16'h7fff);
    push_pixel(16'h8000);
    push_pixel(16'h0000);
    push_pixel(16'h0001);
    push_pixel(16'hffff);
    push_pixel(16'h0100);
    push_pixel(16'h7fff);
    push_pixel(16'h7fff);
    push_pixel(16'h7fff);
    push_pixel(16'h8000);
    wait_idle();

    // Random phases: zero and oversized frame registers, mid-frame shrinks
    run_phase(0,    7,    16'h8000,                   50, 0,  0);
    run_phase(5,    0,    PIX_W'($urandom),           60, 60, 0);
    run_phase(2047, 1024, PIX_W'($urandom),           40, 0,  60);
    run_phase(6,    3,    PIX_W'($urandom),           70, 30, 30);
    run_phase(6,    1,    PIX_W'($urandom),           50, 0,  0);
    run_phase(9,    2047, 16'h7fff,                   60, 60, 0);
    run_phase(3,    4,    PIX_W'($urandom),           60, 0,  60);
    run_phase(16,   5,    PIX_W'($urandom),           60, 30, 30);
    run_phase(1,    1,    16'h0000,                   40, 30, 30);
    run_phase(1024, 2,    PIX_W'($urandom),           40, 0,  0);

    if (err_cnt == 0) begin
      $display("conv2d_causal_window_filter_unit regression: pass");
    end else begin
      $display("conv2d_causal_window_filter_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("conv2d_causal_window_filter_unit regression: fail");
    $finish;
  end

endmodule

/* conv2d_causal_window_filter_unit.f */
hw/rtl/cwf_pkg.sv
hw/rtl/cwf_in_if.sv
hw/rtl/cwf_out_if.sv
hw/rtl/cwf_cfg_regs.sv
hw/rtl/cwf_line_mem.sv
hw/rtl/cwf_mac.sv
hw/rtl/conv2d_causal_window_filter_unit.sv
sim/tb.sv
